### hw/rtl/stereographic_projection_macros.svh
// Assertion macros shared by the projection block
`ifndef STEREOGRAPHIC_PROJECTION_MACROS_SVH
`define STEREOGRAPHIC_PROJECTION_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset
`define SP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/sp_pkg.sv
package sp_pkg;

  localparam int ANG_W        = 32;
  localparam int MAP_W        = 32;
  localparam int TRIG_W       = 34;
  localparam int FRAC         = 30;
  localparam int DIV_SH       = 25;
  localparam int CORDIC_STEPS = 30;

  typedef logic [ANG_W-1:0]         ang_t;
  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [MAP_W-1:0]  map_t;

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

  localparam trig_t CORDIC_START = 34'sd652032874;
  localparam trig_t ONE_Q30      = 34'sd1073741824;
  localparam ang_t  EIGHTH       = 32'h2000_0000;

  // Arctangent of 2^-i in turns, 2^32 per turn
  function automatic logic signed [ANG_W-1:0] atan_turn(input int i);
    logic signed [ANG_W-1:0] v;
    case (i)
      0:  v = 32'sh20000000;  1:  v = 32'sh12E4051E;  2:  v = 32'sh09FB385B;
      3:  v = 32'sh051111D4;  4:  v = 32'sh028B0D43;  5:  v = 32'sh0145D7E1;
      6:  v = 32'sh00A2F61E;  7:  v = 32'sh00517C55;  8:  v = 32'sh0028BE53;
      9:  v = 32'sh00145F2F;  10: v = 32'sh000A2F98;  11: v = 32'sh000517CC;
      12: v = 32'sh00028BE6;  13: v = 32'sh000145F3;  14: v = 32'sh0000A2FA;
      15: v = 32'sh0000517D;  16: v = 32'sh000028BE;  17: v = 32'sh0000145F;
      18: v = 32'sh00000A30;  19: v = 32'sh00000518;  20: v = 32'sh0000028C;
      21: v = 32'sh00000146;  22: v = 32'sh000000A3;  23: v = 32'sh00000051;
      24: v = 32'sh00000029;  25: v = 32'sh00000014;  26: v = 32'sh0000000A;
      27: v = 32'sh00000005;  28: v = 32'sh00000003;  29: v = 32'sh00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Q4.30 product, floored back to Q4.30
  function automatic trig_t qmul(input trig_t a, input trig_t b);
    logic signed [2*TRIG_W-1:0] p;
    p = a * b;
    return p[FRAC+TRIG_W-1:FRAC];
  endfunction

endpackage

### hw/rtl/sp_in_if.sv
interface sp_in_if;
  import sp_pkg::*;
  logic valid;
  logic ready;
  logic signed [ANG_W-1:0] center_lat;
  logic signed [ANG_W-1:0] center_lon;
  logic signed [ANG_W-1:0] point_lat;
  logic signed [ANG_W-1:0] point_lon;

  modport source (output valid, center_lat, center_lon, point_lat, point_lon, input ready);
  modport sink   (input valid, center_lat, center_lon, point_lat, point_lon, output ready);
endinterface

### hw/rtl/sp_out_if.sv
interface sp_out_if;
  import sp_pkg::*;
  logic valid;
  logic ready;
  logic signed [MAP_W-1:0] map_x;
  logic signed [MAP_W-1:0] map_y;
  logic out_of_range;

  modport source (output valid, map_x, map_y, out_of_range, input ready);
  modport sink   (input valid, map_x, map_y, out_of_range, output ready);
endinterface

### hw/rtl/sp_sincos.sv
module sp_sincos #(
  parameter int STEPS = sp_pkg::CORDIC_STEPS
) (
  input  logic          clk,
  input  logic          en,
  input  sp_pkg::ang_t  ang,
  output sp_pkg::trig_t sin_o,
  output sp_pkg::trig_t cos_o
);
  import sp_pkg::*;

  trig_t                   x_r [0:STEPS];
  trig_t                   y_r [0:STEPS];
  logic signed [ANG_W-1:0] z_r [0:STEPS];
  quad_t                   q_r [0:STEPS];
  trig_t                   sin_r, cos_r;

  ang_t  ang_sh;
  quad_t q0;
  assign ang_sh = ang + EIGHTH;
  assign q0     = quad_t'(ang_sh[ANG_W-1 -: 2]);

  // reduce by quarter turns into [-1/8, 1/8) turn
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CORDIC_START;
      y_r[0] <= '0;
      z_r[0] <= $signed(ang - {q0, {(ANG_W-2){1'b0}}});
      q_r[0] <= q0;
    end
  end

  // one rotation step per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_turn(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_turn(i);
        end
        q_r[i+1] <= q_r[i];
      end
    end
  end

  // put the quarter turn back
  always_ff @(posedge clk) begin
    if (en) begin
      case (q_r[STEPS])
        QUAD_0:  begin cos_r <= x_r[STEPS];  sin_r <= y_r[STEPS];  end
        QUAD_1:  begin cos_r <= -y_r[STEPS]; sin_r <= x_r[STEPS];  end
        QUAD_2:  begin cos_r <= -x_r[STEPS]; sin_r <= -y_r[STEPS]; end
        default: begin cos_r <= y_r[STEPS];  sin_r <= -x_r[STEPS]; end
      endcase
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;
endmodule

### hw/rtl/stereographic_projection.sv
// Pipeline from accepted word to result word:
// CORDIC_N + 2 sine/cosine stages, two multiply stages, one combine stage,
// 32 restoring-divide stages (one quotient bit each) and the output register.
// Throughput: one word per cycle; a stall at the output freezes every stage.
// Reset (rst_n low, synchronous) clears all valid bits; data registers keep junk.
`include "stereographic_projection_macros.svh"

module stereographic_projection #(
  parameter int CORDIC_N = sp_pkg::CORDIC_STEPS
) (
  input logic     clk,
  input logic     rst_n,
  sp_in_if.sink   in_ch,
  sp_out_if.source out_ch
);
  import sp_pkg::*;

  localparam int SC_LAT = CORDIC_N + 2;
  localparam int QW     = MAP_W;
  localparam int VLD_N  = SC_LAT + 3 + QW;
  localparam int RW     = TRIG_W - 1 + DIV_SH;
  localparam int DW     = TRIG_W + QW;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
    logic anti;
  } side_t;

  logic en;
  logic [VLD_N-1:0] vld_r;

  // advance whole pipe unless the output word is held
  logic out_v_r;
  assign en          = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[VLD_N-2:0], in_ch.valid};
    end
  end

  // three sine/cosine pipelines
  trig_t s1, c1, s2, c2, sd, cd;
  ang_t  dlon;
  assign dlon = ang_t'(in_ch.point_lon) - ang_t'(in_ch.center_lon);

  sp_sincos #(.STEPS(CORDIC_N)) u_sc_center (
    .clk(clk), .en(en), .ang(ang_t'(in_ch.center_lat)), .sin_o(s1), .cos_o(c1));
  sp_sincos #(.STEPS(CORDIC_N)) u_sc_point (
    .clk(clk), .en(en), .ang(ang_t'(in_ch.point_lat)), .sin_o(s2), .cos_o(c2));
  sp_sincos #(.STEPS(CORDIC_N)) u_sc_dlon (
    .clk(clk), .en(en), .ang(dlon), .sin_o(sd), .cos_o(cd));

  // first products
  trig_t s2s1_r, c1c2_r, nx1_r, s2c1_r, c2s1_r, cd1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s2s1_r <= qmul(s2, s1);
      c1c2_r <= qmul(c1, c2);
      nx1_r  <= qmul(c2, sd);
      s2c1_r <= qmul(s2, c1);
      c2s1_r <= qmul(c2, s1);
      cd1_r  <= cd;
    end
  end

  // second products
  trig_t s2s1_m_r, ccc_r, nx2_r, s2c1_m_r, csc_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s2s1_m_r <= s2s1_r;
      ccc_r    <= qmul(c1c2_r, cd1_r);
      nx2_r    <= nx1_r;
      s2c1_m_r <= s2c1_r;
      csc_r    <= qmul(c2s1_r, cd1_r);
    end
  end

  // combine, take magnitudes and test for quotient overflow
  trig_t den, ny, ax, ay, den_u;
  logic [RW-1:0] dvx, dvy;
  logic [DW-1:0] den_top;
  always_comb begin
    den     = ONE_Q30 + s2s1_m_r + ccc_r;
    ny      = s2c1_m_r - csc_r;
    ax      = nx2_r[TRIG_W-1] ? -nx2_r : nx2_r;
    ay      = ny[TRIG_W-1] ? -ny : ny;
    den_u   = (den > 0) ? den : trig_t'(1);
    dvx     = {ax[TRIG_W-2:0], {DIV_SH{1'b0}}};
    dvy     = {ay[TRIG_W-2:0], {DIV_SH{1'b0}}};
    den_top = {den_u, {QW{1'b0}}};
  end

  logic [RW-1:0]     rx_r  [0:QW];
  logic [RW-1:0]     ry_r  [0:QW];
  logic [QW-1:0]     qx_r  [0:QW];
  logic [QW-1:0]     qy_r  [0:QW];
  logic [TRIG_W-1:0] dd_r  [0:QW];
  side_t             sd_r  [0:QW];

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r[0]       <= dvx;
      ry_r[0]       <= dvy;
      qx_r[0]       <= '0;
      qy_r[0]       <= '0;
      dd_r[0]       <= den_u;
      sd_r[0].neg_x <= nx2_r[TRIG_W-1];
      sd_r[0].neg_y <= ny[TRIG_W-1];
      sd_r[0].ovf_x <= DW'(dvx) >= den_top;
      sd_r[0].ovf_y <= DW'(dvy) >= den_top;
      sd_r[0].anti  <= !(den > 0);
    end
  end

  // restoring divide, one quotient bit per stage, MSB first
  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int B = QW - 1 - k;
    logic [DW-1:0] dsh, tx, ty;
    assign dsh = DW'(dd_r[k]) << B;
    assign tx  = DW'(rx_r[k]);
    assign ty  = DW'(ry_r[k]);
    always_ff @(posedge clk) begin
      if (en) begin
        if (tx >= dsh) begin
          rx_r[k+1] <= RW'(tx - dsh);
          qx_r[k+1] <= {qx_r[k][QW-2:0], 1'b1};
        end else begin
          rx_r[k+1] <= rx_r[k];
          qx_r[k+1] <= {qx_r[k][QW-2:0], 1'b0};
        end
        if (ty >= dsh) begin
          ry_r[k+1] <= RW'(ty - dsh);
          qy_r[k+1] <= {qy_r[k][QW-2:0], 1'b1};
        end else begin
          ry_r[k+1] <= ry_r[k];
          qy_r[k+1] <= {qy_r[k][QW-2:0], 1'b0};
        end
        dd_r[k+1] <= dd_r[k];
        sd_r[k+1] <= sd_r[k];
      end
    end
  end

  // apply sign and saturate
  localparam logic [QW-1:0] MIN_MAG = {1'b1, {(QW-1){1'b0}}};
  side_t sf;
  logic [QW-1:0] ux, uy;
  logic sat_x, sat_y;
  map_t mx, my;
  always_comb begin
    sf = sd_r[QW];
    ux = qx_r[QW];
    uy = qy_r[QW];
    if (sf.neg_x) begin
      sat_x = sf.ovf_x || (ux > MIN_MAG);
      mx    = sat_x ? map_t'(MIN_MAG) : map_t'(-ux);
    end else begin
      sat_x = sf.ovf_x || ux[QW-1];
      mx    = sat_x ? map_t'(~MIN_MAG) : map_t'(ux);
    end
    if (sf.neg_y) begin
      sat_y = sf.ovf_y || (uy > MIN_MAG);
      my    = sat_y ? map_t'(MIN_MAG) : map_t'(-uy);
    end else begin
      sat_y = sf.ovf_y || uy[QW-1];
      my    = sat_y ? map_t'(~MIN_MAG) : map_t'(uy);
    end
  end

  map_t mx_r, my_r;
  logic oor_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= vld_r[VLD_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r  <= sf.anti ? '0 : mx;
      my_r  <= sf.anti ? '0 : my;
      oor_r <= sf.anti || sat_x || sat_y;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.map_x        = mx_r;
  assign out_ch.map_y        = my_r;
  assign out_ch.out_of_range = oor_r;

  `SP_ASSERT_NEXT(a_stall_hold, !en, $stable(vld_r), "pipeline valids moved during stall")
  `SP_ASSERT_NEXT(a_no_loss, en && vld_r[VLD_N-1], out_v_r, "finished word lost")
  `SP_ASSERT_NOW(a_div_rem, vld_r[VLD_N-1] && !sf.anti && !sf.ovf_x && !sf.ovf_y, (DW'(rx_r[QW]) < DW'(dd_r[QW])) && (DW'(ry_r[QW]) < DW'(dd_r[QW])), "divider remainder not below divisor")
endmodule
